### hdl/srqs_pkg.sv
// Shared types, constants and helpers for the sorted ready-queue scheduler.
// Depends on nothing; every other file but srqs_ifs refers to it by scoped names.
package srqs_pkg;

  // Number of job slots in the cell chain.
  localparam int QUEUE_DEPTH = 8;
  // Width that can hold a fill count from zero up to QUEUE_DEPTH.
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  // Ordering mode register codes.
  localparam logic [1:0] MODE_ARRIVAL = 2'd0;
  localparam logic [1:0] MODE_BURST   = 2'd1;
  localparam logic [1:0] MODE_PRIO    = 2'd2;
  localparam logic [1:0] MODE_RESET   = MODE_PRIO;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_INSERTED   = 2'd0,
    STS_DISPATCHED = 2'd1,
    STS_FULL       = 2'd2,
    STS_EMPTY      = 2'd3
  } status_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WRITE
  } state_t;

  // One queued job.
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  burst;
    logic [15:0] arrival;
    logic [3:0]  prio;
  } slot_t;

  // Control that the top level hands to the whole chain.
  typedef struct packed {
    logic       ins;
    logic       dsp;
    logic [1:0] mode;
  } chain_ctl_t;

  // Control that the chain hands to one cell.
  typedef struct packed {
    logic       ins;
    logic       dsp;
    logic       occ;
    logic [1:0] mode;
  } cell_ctl_t;

  // Sort key of a job under the given mode; arrival order and the unused
  // code give every job the same key, so inserts append at the tail.
  function automatic logic [7:0] key_of(slot_t s, logic [1:0] mode);
    logic [7:0] k;
    unique case (mode)
      MODE_BURST: k = s.burst;
      MODE_PRIO:  k = {4'd0, s.prio};
      default:    k = 8'd0;
    endcase
    return k;
  endfunction

endpackage

### hdl/srqs_ifs.sv
// Valid/ready channel interfaces of the sorted ready-queue scheduler.
// Depends on nothing but the field widths of the block.

// Job operation channel.
interface srqs_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  job_id;
  logic [7:0]  burst_len;
  logic [15:0] arrival_stamp;
  logic [3:0]  prio_level;

  modport source (output valid, opcode, job_id, burst_len, arrival_stamp, prio_level,
                  input ready);
  modport sink   (input valid, opcode, job_id, burst_len, arrival_stamp, prio_level,
                  output ready);
endinterface

// Result channel.
interface srqs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  out_job_id;
  logic [15:0] finish_time;
  logic [15:0] turnaround;
  logic [15:0] wait_time;
  logic [3:0]  queue_fill;

  modport source (output valid, status, out_job_id, finish_time, turnaround, wait_time,
                  queue_fill, input ready);
  modport sink   (input valid, status, out_job_id, finish_time, turnaround, wait_time,
                  queue_fill, output ready);
endinterface

// Ordering mode write channel.
interface srqs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### hdl/srqs_cell.sv
// One slot of the sorted job chain: holds a job and trades it with its neighbors.
// Depends on srqs_pkg for the slot and control types and the key function.
module srqs_cell (
  input  logic              clk,
  input  srqs_pkg::cell_ctl_t ctl,
  input  srqs_pkg::slot_t   new_slot,
  input  srqs_pkg::slot_t   left_slot,
  input  srqs_pkg::slot_t   right_slot,
  input  logic              left_at_pos,
  output logic              at_pos,
  output srqs_pkg::slot_t   slot
);

  srqs_pkg::slot_t slot_r;
  logic            gt;

  // This cell is at or behind the insert point when its left neighbor is,
  // when it is free, or when its key is strictly greater than the new job's
  // key. Carrying the left flag keeps the point single even when a mode
  // change has left the queue unsorted under the current keys.
  assign gt     = srqs_pkg::key_of(slot_r, ctl.mode) > srqs_pkg::key_of(new_slot, ctl.mode);
  assign at_pos = left_at_pos || !ctl.occ || gt;
  assign slot   = slot_r;

  // Insert: the first cell at the insert point takes the new job, the ones
  // behind it take their left neighbor. Dispatch: every cell takes its right.
  always_ff @(posedge clk) begin
    if (ctl.dsp) begin
      slot_r <= right_slot;
    end else if (ctl.ins && at_pos) begin
      if (left_at_pos) begin
        slot_r <= left_slot;
      end else begin
        slot_r <= new_slot;
      end
    end
  end

endmodule

### hdl/srqs_chain.sv
// Row of job cells that keeps the ready queue sorted, head at cell zero.
// Depends on srqs_pkg and srqs_cell.
module srqs_chain (
  input  logic                        clk,
  input  srqs_pkg::chain_ctl_t        ctl,
  input  logic [srqs_pkg::FILL_W-1:0] fill,
  input  srqs_pkg::slot_t             new_slot,
  output srqs_pkg::slot_t             head
);

  localparam int N  = srqs_pkg::QUEUE_DEPTH;
  localparam int FW = srqs_pkg::FILL_W;

  srqs_pkg::slot_t slots [N];
  logic [N-1:0]    at_pos;

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      srqs_pkg::cell_ctl_t cctl;
      srqs_pkg::slot_t     left_s;
      srqs_pkg::slot_t     right_s;
      logic                left_p;

      // Occupancy of this cell follows from the fill count.
      assign cctl.ins  = ctl.ins;
      assign cctl.dsp  = ctl.dsp;
      assign cctl.mode = ctl.mode;
      assign cctl.occ  = fill > FW'(i);

      // Neighbor wiring; the first cell sees the new job on its left, the last sees itself on its right.
      if (i == 0) begin : g_first
        assign left_s = new_slot;
        assign left_p = 1'b0;
      end else begin : g_inner
        assign left_s = slots[i-1];
        assign left_p = at_pos[i-1];
      end
      if (i == N - 1) begin : g_last
        assign right_s = slots[i];
      end else begin : g_more
        assign right_s = slots[i+1];
      end

      srqs_cell u_cell (
        .clk        (clk),
        .ctl        (cctl),
        .new_slot   (new_slot),
        .left_slot  (left_s),
        .right_slot (right_s),
        .left_at_pos(left_p),
        .at_pos     (at_pos[i]),
        .slot       (slots[i])
      );
    end
  endgenerate

  assign head = slots[0];

endmodule

### hdl/sorted_ready_queue_scheduler.sv
// Top level of the sorted ready-queue scheduler: sequencer, clock and result logic.
// Depends on srqs_pkg, the channel interfaces in srqs_ifs and srqs_chain.
//
//   channel   direction  payload                                            handshake
//   in_chan   in         opcode, job_id, burst_len, arrival_stamp, prio     valid/ready
//   out_chan  out        status, out_job_id, finish_time, turnaround,       valid/ready
//                        wait_time, queue_fill
//   cfg_chan  in         data = order_mode                                  valid/ready
//
// Each operation passes through an execute state, in which the cell chain shifts and the
// finish time is formed, and a write state, in which the result register is loaded.
// A new operation is taken in the cycle the result register loads.
// A stalled output holds the block in the load cycle; no operation is taken then.
// Reset (rst_n low, synchronous) empties the queue, clears the clock and sets
// the ordering mode to lowest priority number first; the configuration port
// is always ready.
module sorted_ready_queue_scheduler (
  input  logic              clk,
  input  logic              rst_n,
  srqs_in_if.sink           in_chan,
  srqs_out_if.source        out_chan,
  srqs_cfg_if.sink          cfg_chan
);

  localparam int FW = srqs_pkg::FILL_W;

  srqs_pkg::state_t     state_r, state_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [15:0]          clock_r, clock_nxt;
  logic [1:0]           mode_r;
  logic                 op_r;
  srqs_pkg::slot_t      new_r;

  srqs_pkg::status_t    res_status_r, res_status_nxt;
  logic [7:0]           res_id_r, res_id_nxt;
  logic [15:0]          res_end_r, res_end_nxt;
  logic [15:0]          res_arr_r, res_arr_nxt;
  logic [7:0]           res_burst_r, res_burst_nxt;

  logic                 out_valid_r;
  srqs_pkg::status_t    out_status_r;
  logic [7:0]           out_id_r;
  logic [15:0]          out_fin_r, out_tat_r, out_wt_r;
  logic [3:0]           out_fill_r;

  logic                 in_ready;
  logic                 in_acc;
  logic                 exec_en;
  logic                 out_load;
  logic                 full;
  logic                 empty;
  srqs_pkg::chain_ctl_t cctl;
  srqs_pkg::slot_t      head;
  logic [15:0]          start;
  logic [16:0]          sum;
  logic [15:0]          fin;
  logic [15:0]          tat;
  logic [15:0]          wt;

  // Handshakes.
  assign in_acc         = in_chan.valid && in_ready;
  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srqs_pkg::S_IDLE:  if (in_acc) state_nxt = srqs_pkg::S_EXEC;
      srqs_pkg::S_EXEC:  state_nxt = srqs_pkg::S_WRITE;
      srqs_pkg::S_WRITE: begin
        if (out_load) begin
          state_nxt = in_acc ? srqs_pkg::S_EXEC : srqs_pkg::S_IDLE;
        end
      end
      default: state_nxt = srqs_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    exec_en  = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      srqs_pkg::S_IDLE:  in_ready = 1'b1;
      srqs_pkg::S_EXEC:  exec_en = 1'b1;
      srqs_pkg::S_WRITE: begin
        out_load = !out_valid_r || out_chan.ready;
        in_ready = out_load;
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srqs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Ordering mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= srqs_pkg::MODE_RESET;
    end else if (cfg_chan.valid) begin
      mode_r <= cfg_chan.data;
    end
  end

  // Captured operation.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r          <= in_chan.opcode;
      new_r.id      <= in_chan.job_id;
      new_r.burst   <= in_chan.burst_len;
      new_r.arrival <= in_chan.arrival_stamp;
      new_r.prio    <= in_chan.prio_level;
    end
  end

  // Chain control for the execute cycle.
  assign full      = fill_r >= FW'(srqs_pkg::QUEUE_DEPTH);
  assign empty     = fill_r == '0;
  assign cctl.ins  = exec_en && !op_r && !full;
  assign cctl.dsp  = exec_en && op_r && !empty;
  assign cctl.mode = mode_r;

  srqs_chain u_chain (
    .clk     (clk),
    .ctl     (cctl),
    .fill    (fill_r),
    .new_slot(new_r),
    .head    (head)
  );

  // Run the head job: start at the later of clock and arrival, saturate finish.
  assign start = (clock_r > head.arrival) ? clock_r : head.arrival;
  assign sum   = {1'b0, start} + {9'd0, head.burst};
  assign fin   = sum[16] ? 16'hFFFF : sum[15:0];

  // Execute-cycle results, fill count and clock.
  always_comb begin
    fill_nxt       = fill_r;
    clock_nxt      = clock_r;
    res_status_nxt = srqs_pkg::STS_INSERTED;
    res_id_nxt     = 8'd0;
    res_end_nxt    = 16'd0;
    res_arr_nxt    = 16'd0;
    res_burst_nxt  = 8'd0;
    if (!op_r) begin
      if (full) begin
        res_status_nxt = srqs_pkg::STS_FULL;
      end else begin
        fill_nxt = fill_r + FW'(1);
      end
    end else if (empty) begin
      res_status_nxt = srqs_pkg::STS_EMPTY;
    end else begin
      res_status_nxt = srqs_pkg::STS_DISPATCHED;
      fill_nxt       = fill_r - FW'(1);
      clock_nxt      = fin;
      res_id_nxt     = head.id;
      res_end_nxt    = fin;
      res_arr_nxt    = head.arrival;
      res_burst_nxt  = head.burst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      clock_r <= 16'd0;
    end else if (exec_en) begin
      fill_r  <= fill_nxt;
      clock_r <= clock_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      res_status_r <= res_status_nxt;
      res_id_r     <= res_id_nxt;
      res_end_r    <= res_end_nxt;
      res_arr_r    <= res_arr_nxt;
      res_burst_r  <= res_burst_nxt;
    end
  end

  // Turnaround and waiting time; a saturated finish can leave turnaround below the burst, so waiting is held at zero.
  assign tat = res_end_r - res_arr_r;
  assign wt  = (tat >= {8'd0, res_burst_r}) ? (tat - {8'd0, res_burst_r}) : 16'd0;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_fin_r    <= res_end_r;
      out_tat_r    <= tat;
      out_wt_r     <= wt;
      out_fill_r   <= 4'(fill_r);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.out_job_id  = out_id_r;
  assign out_chan.finish_time = out_fin_r;
  assign out_chan.turnaround  = out_tat_r;
  assign out_chan.wait_time   = out_wt_r;
  assign out_chan.queue_fill  = out_fill_r;

endmodule

### hdl/srqs_checker.sv
// Port-level assertions for the sorted ready-queue scheduler and their bind.
// Depends on srqs_pkg and on the top level's channel interfaces.
module srqs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [7:0]  out_job_id,
  input logic [15:0] finish_time,
  input logic [15:0] turnaround,
  input logic [15:0] wait_time,
  input logic [3:0]  queue_fill
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(status) && $stable(out_job_id)
      && $stable(finish_time) && $stable(queue_fill))
    else $error("stalled result changed");

  // An operation occupies the block for its execute cycle.
  a_exec_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("operation taken during the execute cycle");

  // Anything but a dispatch carries zero job fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != srqs_pkg::STS_DISPATCHED |->
      out_job_id == 8'd0 && finish_time == 16'd0 && turnaround == 16'd0
      && wait_time == 16'd0)
    else $error("non-dispatch result with job fields set");

  // An empty report leaves nothing queued, and its waiting does not exceed its turnaround.
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == srqs_pkg::STS_EMPTY |-> queue_fill == 4'd0
      && wait_time <= turnaround)
    else $error("empty report with jobs queued");

endmodule

bind sorted_ready_queue_scheduler srqs_checker u_srqs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .status     (out_chan.status),
  .out_job_id (out_chan.out_job_id),
  .finish_time(out_chan.finish_time),
  .turnaround (out_chan.turnaround),
  .wait_time  (out_chan.wait_time),
  .queue_fill (out_chan.queue_fill)
);

### dv/sorted_ready_queue_scheduler_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted ready-queue scheduler.
// Depends on srqs_pkg, the channel interfaces in srqs_ifs and the scheduler top level.
module sorted_ready_queue_scheduler_test;

  localparam logic       OP_INSERT      = 1'b0;
  localparam logic       OP_DISPATCH    = 1'b1;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam int         WATCHDOG_LIMIT = 500;
  localparam int         SETTLE_CYCLES  = 4;
  localparam int         PHASE_ITEMS    = 150;
  localparam int         SAT_ITEMS      = 50;

  // One result transaction as the block reports it.
  typedef struct packed {
    srqs_pkg::status_t status;
    logic [7:0]  job_id;
    logic [15:0] finish_time;
    logic [15:0] turnaround;
    logic [15:0] wait_time;
    logic [3:0]  queue_fill;
  } job_report_t;

  // Mirror of the ready queue and run clock; it forecasts each report and
  // checks the reports that come back in order.
  class sched_queue_mirror;
    srqs_pkg::slot_t mirror_jobs[$];
    logic [15:0] mirror_clock;
    logic [1:0]  order_mode;
    job_report_t job_reports_due[$];
    int unsigned errors;

    function new();
      order_mode   = srqs_pkg::MODE_RESET;
      mirror_clock = '0;
      errors       = 0;
    endfunction

    function void set_mode(logic [1:0] mode);
      order_mode = mode;
    endfunction

    // Arrival order and the unused code give every job the same key.
    function logic [7:0] sort_key(srqs_pkg::slot_t job);
      case (order_mode)
        srqs_pkg::MODE_BURST: return job.burst;
        srqs_pkg::MODE_PRIO:  return {4'd0, job.prio};
        default:              return 8'd0;
      endcase
    endfunction

    // Apply one accepted operation and queue the report it must produce.
    function void predict_op(logic opcode, srqs_pkg::slot_t job);
      job_report_t     r;
      srqs_pkg::slot_t head;
      int              pos;
      logic [15:0]     start;
      logic [16:0]     stop;
      r = '0;
      if (opcode == OP_INSERT) begin
        if (mirror_jobs.size() >= srqs_pkg::QUEUE_DEPTH) begin
          r.status = srqs_pkg::STS_FULL;
        end else begin
          // Equal keys stay in insertion order.
          pos = 0;
          while (pos < mirror_jobs.size() && sort_key(mirror_jobs[pos]) <= sort_key(job))
            pos++;
          mirror_jobs.insert(pos, job);
          r.status = srqs_pkg::STS_INSERTED;
        end
      end else if (mirror_jobs.size() == 0) begin
        r.status = srqs_pkg::STS_EMPTY;
      end else begin
        // Run the head job to completion; the finish time saturates.
        head  = mirror_jobs.pop_front();
        start = (mirror_clock > head.arrival) ? mirror_clock : head.arrival;
        stop  = {1'b0, start} + head.burst;
        if (stop > 17'h0FFFF) stop = 17'h0FFFF;
        mirror_clock  = stop[15:0];
        r.status      = srqs_pkg::STS_DISPATCHED;
        r.job_id      = head.id;
        r.finish_time = stop[15:0];
        r.turnaround  = stop[15:0] - head.arrival;
        r.wait_time   = (r.turnaround >= head.burst) ? r.turnaround - head.burst : 16'd0;
      end
      r.queue_fill = 4'(mirror_jobs.size());
      job_reports_due.push_back(r);
    endfunction

    function void flag_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare an accepted report with the oldest forecast.
    function void check_report(job_report_t got);
      job_report_t want;
      if (job_reports_due.size() == 0) begin
        $display("%0t ns: report expected none actual status %0d job %0d",
                 $time, got.status, got.job_id);
        errors++;
        return;
      end
      want = job_reports_due.pop_front();
      flag_field("status", want.status, got.status);
      flag_field("job_id", want.job_id, got.job_id);
      flag_field("finish_time", want.finish_time, got.finish_time);
      flag_field("turnaround", want.turnaround, got.turnaround);
      flag_field("wait_time", want.wait_time, got.wait_time);
      flag_field("queue_fill", want.queue_fill, got.queue_fill);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  bit                idling_on;
  int                arrival_now;
  int unsigned       quiet_cycles;
  job_report_t       seen_report;
  sched_queue_mirror sched_mirror;

  srqs_in_if  in_chan();
  srqs_out_if out_chan();
  srqs_cfg_if cfg_chan();

  sorted_ready_queue_scheduler i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random stall bursts while idling is on.
  initial begin
    out_chan.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 4) == 0) begin
        out_chan.ready = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  // Check every accepted result transaction.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen_report.status      = srqs_pkg::status_t'(out_chan.status);
      seen_report.job_id      = out_chan.out_job_id;
      seen_report.finish_time = out_chan.finish_time;
      seen_report.turnaround  = out_chan.turnaround;
      seen_report.wait_time   = out_chan.wait_time;
      seen_report.queue_fill  = out_chan.queue_fill;
      sched_mirror.check_report(seen_report);
    end
  end

  // Watchdog: end the run when no channel moves a transaction for too long.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one operation, with an optional gap first, and wait for acceptance.
  task automatic send_op(input logic opcode, input srqs_pkg::slot_t job);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_chan.valid = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    @(negedge clk);
    in_chan.valid         = 1'b1;
    in_chan.opcode        = opcode;
    in_chan.job_id        = job.id;
    in_chan.burst_len     = job.burst;
    in_chan.arrival_stamp = job.arrival;
    in_chan.prio_level    = job.prio;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    sched_mirror.predict_op(opcode, job);
  endtask

  task automatic insert_job(input logic [7:0] id, input logic [7:0] burst,
                            input logic [15:0] arrival, input logic [3:0] prio);
    send_op(OP_INSERT, '{id: id, burst: burst, arrival: arrival, prio: prio});
  endtask

  task automatic dispatch_jobs(input int count);
    repeat (count) send_op(OP_DISPATCH, '{id: 8'hFF, burst: 8'hFF, arrival: 16'hFFFF,
                                          prio: 4'hF});
  endtask

  // Stop offering work and wait until every forecast report has arrived.
  task automatic settle();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (sched_mirror.job_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_order_mode(input logic [1:0] mode);
    settle();
    @(negedge clk);
    cfg_chan.valid = 1'b1;
    cfg_chan.data  = mode;
    @(posedge clk);
    while (cfg_chan.ready !== 1'b1) @(posedge clk);
    sched_mirror.set_mode(mode);
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  // Runs of mostly inserts or mostly dispatches swing the queue between
  // empty and full; wide_stamps spreads arrivals over the whole range.
  task automatic run_random_phase(input int count, input bit wide_stamps);
    int              run_left;
    logic            run_op;
    logic            opcode;
    srqs_pkg::slot_t job;
    run_left = 0;
    run_op   = OP_INSERT;
    repeat (count) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 10);
        run_op   = 1'($urandom_range(0, 1));
      end
      opcode = ($urandom_range(0, 6) == 0) ? ~run_op : run_op;
      job.id = 8'($urandom_range(0, 255));
      if (wide_stamps) begin
        job.burst   = 8'($urandom_range(0, 255));
        job.arrival = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(65280, 65535))
                                                  : 16'($urandom_range(0, 65535));
      end else begin
        job.burst   = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15))
                                                 : 8'($urandom_range(0, 255));
        arrival_now = arrival_now + $urandom_range(0, 20);
        job.arrival = 16'(arrival_now + $urandom_range(0, 40));
      end
      job.prio = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3))
                                             : 4'($urandom_range(0, 15));
      send_op(opcode, job);
      run_left--;
    end
  endtask

  // Main sequence: reset, directed checks, random phases over all modes.
  initial begin
    logic [1:0] phase_modes[8];
    phase_modes = '{srqs_pkg::MODE_ARRIVAL, srqs_pkg::MODE_BURST, MODE_UNUSED,
                    srqs_pkg::MODE_PRIO, srqs_pkg::MODE_BURST, srqs_pkg::MODE_ARRIVAL,
                    srqs_pkg::MODE_PRIO, srqs_pkg::MODE_BURST};
    rst_n                 = 1'b0;
    idling_on             = 1'b0;
    arrival_now           = 0;
    quiet_cycles          = 0;
    in_chan.valid         = 1'b0;
    in_chan.opcode        = OP_INSERT;
    in_chan.job_id        = '0;
    in_chan.burst_len     = '0;
    in_chan.arrival_stamp = '0;
    in_chan.prio_level    = '0;
    cfg_chan.valid        = 1'b0;
    cfg_chan.data         = srqs_pkg::MODE_RESET;
    sched_mirror          = new();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Priority order after reset: empty dispatch, ties, a full queue.
    dispatch_jobs(1);
    insert_job(8'h00, 8'd0,   16'd0,   4'd15);
    insert_job(8'hFF, 8'd255, 16'd16,  4'd0);
    insert_job(8'h11, 8'd5,   16'd3,   4'd7);
    insert_job(8'h12, 8'd6,   16'd3,   4'd7);
    insert_job(8'h13, 8'd1,   16'd2,   4'd15);
    insert_job(8'h14, 8'd2,   16'd100, 4'd0);
    insert_job(8'h15, 8'd9,   16'd50,  4'd8);
    insert_job(8'h16, 8'd3,   16'd7,   4'd1);
    insert_job(8'h17, 8'd4,   16'd8,   4'd2);
    dispatch_jobs(4);

    // Shortest burst on a queue sorted by priority: no re-sorting, then drain.
    write_order_mode(srqs_pkg::MODE_BURST);
    insert_job(8'h21, 8'd200, 16'd20, 4'd0);
    insert_job(8'h22, 8'd0,   16'd30, 4'd15);
    dispatch_jobs(7);

    // Random phases, idling on every other phase.
    foreach (phase_modes[p]) begin
      write_order_mode(phase_modes[p]);
      idling_on = (p % 2 == 0);
      run_random_phase(PHASE_ITEMS, 1'b0);
    end

    // Saturating clock with full-range stamps, no idling.
    write_order_mode(srqs_pkg::MODE_PRIO);
    idling_on = 1'b0;
    run_random_phase(SAT_ITEMS, 1'b1);

    settle();
    if (sched_mirror.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
